[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the dot span renderer.
// Uses the clk and rst_n names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/jdsr_pkg.sv]
// Package for the joystick dot span renderer: widths, reset values,
// register indexes and the circle half-width table. No dependencies.
package jdsr_pkg;

  localparam int DOT_RADIUS = 8;
  localparam int RAW_W      = 12;
  localparam int COORD_W    = 9;
  localparam int COLOR_W    = 16;
  localparam int PROD_W     = RAW_W + COORD_W;
  localparam int SIGNED_W   = COORD_W + 2;
  localparam int ROW_LAST   = 2 * DOT_RADIUS;
  localparam int ROW_IDX_W  = $clog2(ROW_LAST + 1);

  // Full scale is 2^RAW_W - 1, so a quotient by it folds with a shift
  localparam int AXIS_FULL_SCALE = (1 << RAW_W) - 1;
  localparam int HALF_SCALE      = AXIS_FULL_SCALE / 2;

  localparam int IN_DATA_W  = 2 * RAW_W;
  localparam int SPAN_BITS  = 3 * COORD_W + COLOR_W;
  localparam int OUT_DATA_W = ((SPAN_BITS + 7) / 8) * 8;

  localparam logic [COORD_W-1:0] RESET_WIDTH   = COORD_W'(240);
  localparam logic [COORD_W-1:0] RESET_HEIGHT  = COORD_W'(240);
  localparam logic [COLOR_W-1:0] RESET_BG      = COLOR_W'(0);
  localparam logic [COLOR_W-1:0] RESET_ACTIVE  = COLOR_W'(2047);

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_COLOR  = 2'd3;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] last_column;
    logic [COORD_W-1:0] first_column;
    logic [COORD_W-1:0] row;
  } span_t;

  // Largest h with h*h + d*d <= R*R: a constant table of ROW_LAST/2+1 entries
  function automatic logic [COORD_W-1:0] half_width(input logic [ROW_IDX_W-1:0] d);
    logic [COORD_W-1:0] h;
    int dd;
    h  = '0;
    dd = int'(d) * int'(d);
    for (int k = 1; k <= DOT_RADIUS; k++) begin
      if (k * k + dd <= DOT_RADIUS * DOT_RADIUS) h = COORD_W'(k);
    end
    return h;
  endfunction

endpackage

[rtl/joystick_dot_span_renderer_top.sv]
// Joystick dot span renderer, top level.
// Depends on jdsr_pkg and assert_macros.svh.

// One joystick sample (raw_x, raw_y) moves a filled dot of radius DOT_RADIUS
// on a screen of screen_width x screen_height pixels. Each axis is scaled into
// the screen with a DOT_RADIUS margin, rounded to nearest and clamped to the
// last pixel. The block then emits one output word per visible circle row, as
// a span [first_column, last_column] on that row: first the spans that erase
// the previous dot in background_color (skipped for the first sample after
// reset), then the spans of the new dot in active_color, rows top to bottom,
// clipped to the screen. tlast marks the final span of a sample; a sample
// whose new and erased dots are both wholly off screen produces no words.
// Timing: in_tready is high only while the block is idle. A sample passes
// through the shared multiply/scale unit (one multiply and one scale step per
// axis), then through the shared span unit one circle row at a time,
// 2*DOT_RADIUS+1 rows per circle, and then a flush step for the final span.
// A visible row waits while a span is pending and the output register is
// full with out_tready low. Configuration registers are written through
// cfg_we/cfg_index/cfg_data and must only change while idle.
module joystick_dot_span_renderer_top
  import jdsr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Sample input; in_tdata: raw_x [11:0], raw_y [23:12]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // Span output; out_tdata: row [8:0], first_column [17:9],
  // last_column [26:18], color [42:27], zero fill above
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tlast,
  // Register writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]     cfg_data
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_ROWS,
    S_FLUSH
  } state_t;

  // Configuration registers
  logic [COORD_W-1:0] width_r, height_r;
  logic [COLOR_W-1:0] bg_color_r, active_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r        <= RESET_WIDTH;
      height_r       <= RESET_HEIGHT;
      bg_color_r     <= RESET_BG;
      active_color_r <= RESET_ACTIVE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_r        <= cfg_data[COORD_W-1:0];
        REG_SCREEN_HEIGHT: height_r       <= cfg_data[COORD_W-1:0];
        REG_BG_COLOR:      bg_color_r     <= cfg_data;
        REG_ACTIVE_COLOR:  active_color_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  state_t               state_r;
  logic                 axis_sel_r;   // 0: x axis, 1: y axis
  logic                 erase_r;      // drawing the erase circle
  logic [ROW_IDX_W-1:0] row_idx_r;
  logic [RAW_W-1:0]     raw_x_r, raw_y_r;
  logic [PROD_W-1:0]    product_r;
  logic [COORD_W-1:0]   new_x_r, new_y_r;
  logic [COORD_W-1:0]   prev_x_r, prev_y_r;
  logic                 dot_present_r;
  logic                 pend_valid_r;
  span_t                pend_span_r;
  logic                 out_valid_r;
  logic                 out_last_r;
  span_t                out_span_r;

  // Shared scale unit: coord = (raw*span + HALF_SCALE) / FULL_SCALE + R, at most extent-1 (R if extent <= 2R)
  logic [RAW_W-1:0]     raw_sel;
  logic [COORD_W-1:0]   extent_sel;
  logic [COORD_W-1:0]   span_sel;
  logic [PROD_W-1:0]    rounded;
  logic [COORD_W-1:0]   quot_hi;
  logic [RAW_W:0]       fold;
  logic [COORD_W:0]     quot;
  logic [COORD_W:0]     pos;
  logic [COORD_W-1:0]   top;
  logic [COORD_W-1:0]   coord;

  assign raw_sel    = axis_sel_r ? raw_y_r : raw_x_r;
  assign extent_sel = axis_sel_r ? height_r : width_r;
  assign span_sel   = extent_sel - COORD_W'(2 * DOT_RADIUS + 1);
  assign rounded    = product_r + PROD_W'(HALF_SCALE);
  // n / (2^k - 1): quotient n>>k, remainder (n mod 2^k) + (n>>k); one correction
  assign quot_hi    = rounded[PROD_W-1:RAW_W];
  assign fold       = {1'b0, rounded[RAW_W-1:0]} + (RAW_W+1)'(quot_hi);
  assign quot       = {1'b0, quot_hi} +
                      (COORD_W+1)'(fold >= (RAW_W+1)'(AXIS_FULL_SCALE));
  assign pos        = quot + (COORD_W+1)'(DOT_RADIUS);
  assign top        = extent_sel - COORD_W'(1);

  always_comb begin
    if ({1'b0, extent_sel} <= (COORD_W+1)'(2 * DOT_RADIUS)) begin
      coord = COORD_W'(DOT_RADIUS);
    end else if (pos > {1'b0, top}) begin
      coord = top;
    end else begin
      coord = pos[COORD_W-1:0];
    end
  end

  // Shared span unit: one circle row per cycle unless a visible row waits on a full output
  logic [COORD_W-1:0]   cx, cy;
  logic [SIGNED_W-1:0]  row_y;
  logic [ROW_IDX_W-1:0] row_dist;
  logic [COORD_W-1:0]   half;
  logic [SIGNED_W-1:0]  left_s;
  logic [COORD_W:0]     right_u;
  logic [COORD_W-1:0]   left_clip, right_clip;
  logic                 row_vis;
  span_t                row_span;

  assign cx       = erase_r ? prev_x_r : new_x_r;
  assign cy       = erase_r ? prev_y_r : new_y_r;
  assign row_y    = SIGNED_W'(cy) + SIGNED_W'(row_idx_r) - SIGNED_W'(DOT_RADIUS);
  assign row_dist = (row_idx_r >= ROW_IDX_W'(DOT_RADIUS)) ?
                    row_idx_r - ROW_IDX_W'(DOT_RADIUS) :
                    ROW_IDX_W'(DOT_RADIUS) - row_idx_r;
  assign half     = half_width(row_dist);
  assign left_s   = SIGNED_W'(cx) - SIGNED_W'(half);
  assign right_u  = (COORD_W+1)'(cx) + (COORD_W+1)'(half);

  always_comb begin
    left_clip  = left_s[SIGNED_W-1] ? '0 : left_s[COORD_W-1:0];
    right_clip = (right_u >= {1'b0, width_r}) ? width_r - COORD_W'(1)
                                              : right_u[COORD_W-1:0];
    row_vis    = !row_y[SIGNED_W-1] &&
                 (row_y[COORD_W:0] < {1'b0, height_r}) &&
                 (width_r != '0) &&
                 (left_clip <= right_clip);
    row_span.row          = row_y[COORD_W-1:0];
    row_span.first_column = left_clip;
    row_span.last_column  = right_clip;
    row_span.color        = erase_r ? bg_color_r : active_color_r;
  end

  // Hold one span back so the final one of a sample can carry tlast
  logic out_free;
  logic row_step;
  logic push_pend;
  logic row_end;

  assign out_free  = !out_valid_r || out_tready;
  assign row_step  = (state_r == S_ROWS) && (!row_vis || !pend_valid_r || out_free);
  assign push_pend = (row_step && row_vis && pend_valid_r) ||
                     ((state_r == S_FLUSH) && pend_valid_r && out_free);
  assign row_end   = (row_idx_r == ROW_IDX_W'(ROW_LAST));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      axis_sel_r    <= 1'b0;
      erase_r       <= 1'b0;
      row_idx_r     <= '0;
      prev_x_r      <= '0;
      prev_y_r      <= '0;
      dot_present_r <= 1'b0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      // Output register: load from the pending slot, drop when taken
      if (push_pend) begin
        out_valid_r <= 1'b1;
        out_span_r  <= pend_span_r;
        out_last_r  <= (state_r == S_FLUSH);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            raw_x_r    <= in_tdata[RAW_W-1:0];
            raw_y_r    <= in_tdata[IN_DATA_W-1:RAW_W];
            axis_sel_r <= 1'b0;
            state_r    <= S_MUL;
          end
        end
        S_MUL: begin
          product_r <= PROD_W'(raw_sel) * PROD_W'(span_sel);
          state_r   <= S_DIV;
        end
        S_DIV: begin
          if (axis_sel_r) begin
            new_y_r   <= coord;
            erase_r   <= dot_present_r;
            row_idx_r <= '0;
            state_r   <= S_ROWS;
          end else begin
            new_x_r    <= coord;
            axis_sel_r <= 1'b1;
            state_r    <= S_MUL;
          end
        end
        S_ROWS: begin
          if (row_step) begin
            if (row_vis) begin
              pend_valid_r <= 1'b1;
              pend_span_r  <= row_span;
            end
            // Advance the row; switch from erase to draw, then flush
            if (row_end) begin
              row_idx_r <= '0;
              if (erase_r) begin
                erase_r <= 1'b0;
              end else begin
                prev_x_r      <= new_x_r;
                prev_y_r      <= new_y_r;
                dot_present_r <= 1'b1;
                state_r       <= S_FLUSH;
              end
            end else begin
              row_idx_r <= row_idx_r + ROW_IDX_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_W'(out_span_r);

  // Checks
  `ASSERT_CLK(a_idle_no_pending, in_tready |-> !pend_valid_r,
              "span left pending while idle")
  `ASSERT_CLK(a_accept_starts_map, (in_tvalid && in_tready) |=> (state_r == S_MUL),
              "accepted sample did not start the scale unit")
  `ASSERT_CLK(a_span_ordered, out_valid_r |-> (out_span_r.first_column <= out_span_r.last_column),
              "span with first column past last column")
  `ASSERT_CLK(a_dot_sticky, dot_present_r |=> dot_present_r,
              "dot flag cleared outside reset")
  `ASSERT_CLK(a_row_idx_range, row_idx_r <= ROW_IDX_W'(ROW_LAST),
              "row index beyond circle")

endmodule

[tb/tb_joystick_dot_span_renderer_top.sv]
// Self-checking testbench for joystick_dot_span_renderer_top: a scoreboard class
// predicts the erase and draw spans of every accepted sample and checks each word.
// Depends on jdsr_pkg and the RTL of the block only.
module tb_joystick_dot_span_renderer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jdsr_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_PERCENT = 8;
  // Wait after the last owed span so any late extra word has time to show
  localparam int SETTLE       = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 16;

  // One expected span word
  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] first_column;
    logic [COORD_W-1:0] last_column;
    logic [COLOR_W-1:0] color;
    logic               last;
  } span_word_t;

  // Tracks the dot position and the registers, and holds the spans still owed
  class dot_span_predictor;
    int         screen_w;
    int         screen_h;
    int         erase_color;
    int         draw_color;
    int         prev_x;
    int         prev_y;
    bit         has_dot;
    span_word_t expected_spans[$];
    int         mismatches;
    int         spans_seen;

    function new();
      screen_w    = int'(RESET_WIDTH);
      screen_h    = int'(RESET_HEIGHT);
      erase_color = int'(RESET_BG);
      draw_color  = int'(RESET_ACTIVE);
      prev_x      = 0;
      prev_y      = 0;
      has_dot     = 1'b0;
      mismatches  = 0;
      spans_seen  = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [COLOR_W-1:0] value);
      case (index)
        REG_SCREEN_WIDTH:  screen_w    = int'(value[COORD_W-1:0]);
        REG_SCREEN_HEIGHT: screen_h    = int'(value[COORD_W-1:0]);
        REG_BG_COLOR:      erase_color = int'(value);
        REG_ACTIVE_COLOR:  draw_color  = int'(value);
        default: ;
      endcase
    endfunction

    // Scale a raw axis into [R, extent-1-R], round to nearest, clamp to the last pixel
    function int axis_position(int raw, int extent);
      int top;
      int pos;
      top = (extent == 0) ? 0 : extent - 1;
      if (extent <= 2 * DOT_RADIUS) return DOT_RADIUS;
      pos = (raw * (top - 2 * DOT_RADIUS) + HALF_SCALE) / AXIS_FULL_SCALE + DOT_RADIUS;
      return (pos > top) ? top : pos;
    endfunction

    // Queue one span per visible row of the circle, clipped to the screen
    function void push_circle(int cx, int cy, int color);
      int y;
      int half;
      int left;
      int right;
      span_word_t w;
      for (int dy = -DOT_RADIUS; dy <= DOT_RADIUS; dy++) begin
        y = cy + dy;
        if (y < 0 || y >= screen_h) continue;
        half = 0;
        while ((half + 1) * (half + 1) + dy * dy <= DOT_RADIUS * DOT_RADIUS) half++;
        left  = (cx - half < 0) ? 0 : cx - half;
        right = (cx + half > screen_w - 1) ? screen_w - 1 : cx + half;
        if (left > right) continue;
        w.row          = COORD_W'(y);
        w.first_column = COORD_W'(left);
        w.last_column  = COORD_W'(right);
        w.color        = COLOR_W'(color);
        w.last         = 1'b0;
        expected_spans.push_back(w);
      end
    endfunction

    function void note_sample(logic [RAW_W-1:0] raw_x, logic [RAW_W-1:0] raw_y);
      int nx;
      int ny;
      int before_count;
      nx = axis_position(int'(raw_x), screen_w);
      ny = axis_position(int'(raw_y), screen_h);
      before_count = expected_spans.size();
      if (has_dot) push_circle(prev_x, prev_y, erase_color);
      push_circle(nx, ny, draw_color);
      if (expected_spans.size() > before_count)
        expected_spans[expected_spans.size() - 1].last = 1'b1;
      prev_x  = nx & ((1 << COORD_W) - 1);
      prev_y  = ny & ((1 << COORD_W) - 1);
      has_dot = 1'b1;
    endfunction

    function void check_span(logic [OUT_DATA_W-1:0] data, logic tlast);
      span_word_t exp_w;
      span_t      got;
      got = data[SPAN_BITS-1:0];
      spans_seen++;
      if (expected_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("span %0d arrived with nothing expected: row %0d cols %0d..%0d color %h last %b",
                   spans_seen, got.row, got.first_column, got.last_column, got.color, tlast);
        return;
      end
      exp_w = expected_spans.pop_front();
      if (got.row !== exp_w.row || got.first_column !== exp_w.first_column ||
          got.last_column !== exp_w.last_column || got.color !== exp_w.color ||
          tlast !== exp_w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("span %0d mismatch: expected row %0d cols %0d..%0d color %h last %b, got row %0d cols %0d..%0d color %h last %b",
                   spans_seen, exp_w.row, exp_w.first_column, exp_w.last_column, exp_w.color,
                   exp_w.last, got.row, got.first_column, got.last_column, got.color, tlast);
      end
    endfunction

    function int pending();
      return expected_spans.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // in_tdata: raw_x [11:0], raw_y [23:12]
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // out_tdata: row [8:0], first_column [17:9], last_column [26:18], color [42:27]
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]     cfg_data;

  dot_span_predictor predictor;
  // steady: no idling on either side; hold_request: ask the receiver for a long hold-off
  bit                steady;
  bit                hold_request;

  joystick_dot_span_renderer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Stop a hung run: a stuck handshake or a missing span ends up here
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Check every word the block hands over, at the edge where it moves
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) predictor.check_span(out_tdata, out_tlast);
  end

  // Receiver: idle at random, hold off for a long counted stretch on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_tready   <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Offer one sample from a falling edge; return at the falling edge after it is taken
  task automatic send_sample(input logic [RAW_W-1:0] raw_x, input logic [RAW_W-1:0] raw_y);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {raw_y, raw_x};
    do @(posedge clk); while (!in_tready);
    predictor.note_sample(raw_x, raw_y);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed span, then let the last sample finish its flush
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (predictor.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write all four registers back to back while the block is idle
  task automatic load_registers(input int width, input int height,
                                input int erase_c, input int draw_c);
    logic [COLOR_W-1:0] values[4];
    logic [CFG_INDEX_W-1:0] idx[4];
    values = '{COLOR_W'(width), COLOR_W'(height), COLOR_W'(erase_c), COLOR_W'(draw_c)};
    idx    = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_BG_COLOR, REG_ACTIVE_COLOR};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= values[i];
      predictor.set_register(idx[i], values[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly uniform raw values, with the axis ends mixed in
  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return RAW_W'($urandom_range(AXIS_FULL_SCALE));
    endcase
  endfunction

  initial begin
    int widths[6];
    int heights[6];
    predictor    = new();
    steady       = 1'b0;
    hold_request = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed samples at the reset registers; the first one draws with no erase
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd2047, 12'd2048);
    send_sample(12'hAAA, 12'h555);
    send_sample(12'h555, 12'hAAA);
    send_sample(12'd1, 12'd4094);
    wait_drained();

    // Register settings: both extremes of the screen, then tall, wide and random shapes.
    // Moving from tall to wide can leave the old dot off screen, so its erase may be clipped away.
    widths  = '{17, 320, 17, 320, 0, 0};
    heights = '{17, 320, 320, 17, 0, 0};
    for (int p = 0; p < 6; p++) begin
      if (widths[p] == 0) begin
        widths[p]  = $urandom_range(17, 320);
        heights[p] = $urandom_range(17, 320);
      end
      case (p)
        0:       load_registers(widths[p], heights[p], 16'h0000, 16'hFFFF);
        1:       load_registers(widths[p], heights[p], 16'hFFFF, 16'h0000);
        default: load_registers(widths[p], heights[p], $urandom_range(16'hFFFF),
                                $urandom_range(16'hFFFF));
      endcase
      // Run one phase without idling, and stall the output hard in another
      steady = (p == 1);
      if (p == 2) hold_request = 1'b1;
      send_sample(12'd0, 12'd4095);
      send_sample(12'd4095, 12'd0);
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_raw(), pick_raw());
      wait_drained();
      steady = 1'b0;
    end

    if (predictor.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
